/* sv/first_fit_block_allocator_core_macros.svh */
// assertion macros shared by the allocator rtl
// expects clk and arst_n in the scope of each use
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ffba_pkg.sv */
// shared types and codes of the first-fit allocator
// no dependencies
package ffba_pkg;

	localparam int DATA_W = 32;
	localparam int CALC_W = 34;
	localparam int STAT_W = 3;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STAT_W-1:0] ST_INVAL   = 3'd4;

	// register indexes (byte address bit 2)
	localparam logic REG_HEAP_START = 1'b0;
	localparam logic REG_HEAP_END   = 1'b1;

	// search token walking the cell row
	typedef struct packed {
		logic              act;
		logic              cmd;
		logic [CALC_W-1:0] key;
		logic              hit;
		logic              was_free;
		logic [DATA_W-1:0] hit_addr;
	} probe_t;

endpackage

/* sv/first_fit_block_allocator_core.sv */
// first-fit allocator, one command at a time; states from input transfer to the output register:
// a free of address zero goes straight to FIN, other frees search the cell row and then go to FIN,
// an allocate rounds and dispatches (zero or oversize to FIN), searches, and on a miss with room carves and places
// a new command is taken in the cycle after its predecessor leaves FIN, never while one is in flight,
// and FIN waits while a result still sits unread in the output register
// arst_n clears the table state, the fill count and the break; heap_start 0, heap_end 65536
`include "first_fit_block_allocator_core_macros.svh"

module first_fit_block_allocator_core #(
	parameter int MAX_BLOCKS   = 64,
	parameter int ALIGN_BYTES  = 16,
	parameter int HEADER_BYTES = 32,
	parameter int ADDR_BITS    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [ffba_pkg::DATA_W-1:0]   pwdata,
	output logic [ffba_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// command channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [ffba_pkg::DATA_W-1:0]   req_size,
	input  logic [ffba_pkg::DATA_W-1:0]   user_addr,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffba_pkg::DATA_W-1:0]   result_addr,
	output logic [ffba_pkg::STAT_W-1:0]   status,
	output logic                          reused
);

	localparam int DW       = ffba_pkg::DATA_W;
	localparam int CW       = ffba_pkg::CALC_W;
	localparam int SW       = ffba_pkg::STAT_W;
	localparam int CNTW     = $clog2(MAX_BLOCKS + 1);
	localparam int RW       = $clog2(ALIGN_BYTES) + 1;
	localparam int LIM_BITS = (ADDR_BITS < CW) ? ADDR_BITS : CW;

	// controller states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ROUND  = 3'd1;
	localparam logic [2:0] ST_DISP   = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_CARVE  = 3'd4;
	localparam logic [2:0] ST_PLACE  = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	// true when a value leaves the address range
	function automatic logic over_range(input logic [CW-1:0] v);
		return |(v >> LIM_BITS);
	endfunction

	logic [2:0]      state_q;
	logic [DW-1:0]   heap_start_q;
	logic [DW-1:0]   heap_end_q;
	logic [DW-1:0]   heap_break_q;
	logic [CNTW-1:0] count_q;

	logic            cmd_q;
	logic [DW-1:0]   size_q;
	logic [CW-1:0]   asz_q;
	logic [CW-1:0]   abrk_q;
	logic            size_bad_q;
	logic            brk_bad_q;
	logic [CW-1:0]   user_q;
	logic            user_bad_q;

	logic [DW-1:0]   pend_addr_q;
	logic [SW-1:0]   pend_status_q;
	logic            pend_reused_q;

	logic            out_valid_q;
	logic [DW-1:0]   result_addr_q;
	logic [SW-1:0]   status_q;
	logic            reused_q;

	logic            accept;
	logic            cfg_wr;
	logic [DW-1:0]   brk_sel;
	logic            rem_start;
	logic            size_done;
	logic            brk_done;
	logic [RW-1:0]   size_rem;
	logic [RW-1:0]   brk_rem;
	logic [CW-1:0]   asz;
	logic [CW-1:0]   abrk;
	logic [CW-1:0]   user_sum;
	logic [CW-1:0]   end_sum;
	logic            place_bad;
	logic            place_ok;
	logic            out_free;

	ffba_pkg::probe_t launch;
	ffba_pkg::probe_t probe_exit;
	ffba_pkg::probe_t chain [MAX_BLOCKS+1];

	// ---------------------------------------------------------------------
	// register port: paddr bit 2 selects the register, pready tied high
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == ffba_pkg::REG_HEAP_END) ? heap_end_q : heap_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q <= '0;
			heap_end_q   <= DW'(65536);
		end else if (cfg_wr) begin
			if (paddr[2] == ffba_pkg::REG_HEAP_END) begin
				heap_end_q <= pwdata;
			end else begin
				heap_start_q <= pwdata;
			end
		end
	end

	// ---------------------------------------------------------------------
	// alignment: remainders of size and break by ALIGN_BYTES, in parallel
	// ---------------------------------------------------------------------
	assign accept    = in_valid && in_ready;
	assign rem_start = accept && (cmd == ffba_pkg::CMD_ALLOC);
	// an empty table carves from heap_start
	assign brk_sel   = (count_q == '0) ? heap_start_q : heap_break_q;

	ffba_rem #(.ALIGN(ALIGN_BYTES), .RW(RW)) u_size_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rem_start),
		.value (req_size),
		.done  (size_done),
		.rem   (size_rem)
	);

	ffba_rem #(.ALIGN(ALIGN_BYTES), .RW(RW)) u_brk_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rem_start),
		.value (brk_sel),
		.done  (brk_done),
		.rem   (brk_rem)
	);

	// round up by adding the distance to the next multiple
	always_comb begin
		asz  = {2'b00, size_q};
		abrk = {2'b00, brk_sel};
		if (size_rem != '0) begin
			asz = asz + (CW'(ALIGN_BYTES) - CW'(size_rem));
		end
		if (brk_rem != '0) begin
			abrk = abrk + (CW'(ALIGN_BYTES) - CW'(brk_rem));
		end
	end

	// ---------------------------------------------------------------------
	// cell row: the token enters cell 0, is registered in each cell in turn and exits the last
	// ---------------------------------------------------------------------
	always_comb begin
		launch = '0;
		if (state_q == ST_IDLE) begin
			// free with nonzero address searches at once
			launch.act = accept && (cmd == ffba_pkg::CMD_FREE) && (user_addr != '0);
			launch.cmd = ffba_pkg::CMD_FREE;
			launch.key = {2'b00, user_addr};
		end else begin
			launch.act = (state_q == ST_DISP) && (size_q != '0) && !size_bad_q;
			launch.cmd = ffba_pkg::CMD_ALLOC;
			launch.key = asz_q;
		end
	end

	assign chain[0] = launch;

	for (genvar gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
		ffba_cell #(.IDX(gi), .CNTW(CNTW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.wr_en    (place_ok),
			.wr_addr  (user_q[DW-1:0]),
			.wr_bytes (asz_q[DW-1:0]),
			.probe_in (chain[gi]),
			.probe_out(chain[gi+1])
		);
	end

	assign probe_exit = chain[MAX_BLOCKS];

	// ---------------------------------------------------------------------
	// carving a new block at the break
	// ---------------------------------------------------------------------
	assign user_sum  = abrk_q + CW'(HEADER_BYTES);
	assign end_sum   = user_q + asz_q;
	assign place_bad = user_bad_q || over_range(end_sum) || (end_sum > {2'b00, heap_end_q});
	assign place_ok  = (state_q == ST_PLACE) && !place_bad;

	// ---------------------------------------------------------------------
	// controller
	// ---------------------------------------------------------------------
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			heap_break_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// output register fills from FIN and drains on a result transfer
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == ffba_pkg::CMD_ALLOC) begin
							state_q <= ST_ROUND;
						end else if (user_addr == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_ROUND: begin
					if (size_done && brk_done) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (size_q == '0 || size_bad_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (probe_exit.act) begin
						if (cmd_q == ffba_pkg::CMD_ALLOC && !probe_exit.hit &&
							count_q != CNTW'(MAX_BLOCKS)) begin
							state_q <= ST_CARVE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_CARVE: begin
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					if (place_ok) begin
						count_q      <= count_q + CNTW'(1);
						heap_break_q <= end_sum[DW-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// transfer to the output register once it is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the controller
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q         <= cmd;
					size_q        <= req_size;
					pend_addr_q   <= '0;
					pend_status_q <= ffba_pkg::ST_OK;
					pend_reused_q <= 1'b0;
				end
			end
			ST_ROUND: begin
				asz_q      <= asz;
				abrk_q     <= abrk;
				size_bad_q <= over_range({2'b00, size_q}) || over_range(asz);
				brk_bad_q  <= over_range({2'b00, brk_sel}) || over_range(abrk);
			end
			ST_DISP: begin
				if (size_q == '0) begin
					pend_status_q <= ffba_pkg::ST_ZERO;
				end else if (size_bad_q) begin
					pend_status_q <= ffba_pkg::ST_NOSPACE;
				end
			end
			ST_SEARCH: begin
				if (probe_exit.act) begin
					if (cmd_q == ffba_pkg::CMD_FREE) begin
						// already free or unknown address
						if (!probe_exit.hit || probe_exit.was_free) begin
							pend_status_q <= ffba_pkg::ST_INVAL;
						end
					end else if (probe_exit.hit) begin
						pend_addr_q   <= probe_exit.hit_addr;
						pend_reused_q <= 1'b1;
					end else if (count_q == CNTW'(MAX_BLOCKS)) begin
						pend_status_q <= ffba_pkg::ST_FULL;
					end
				end
			end
			ST_CARVE: begin
				user_q     <= user_sum;
				user_bad_q <= brk_bad_q || over_range(user_sum);
			end
			ST_PLACE: begin
				if (place_bad) begin
					pend_status_q <= ffba_pkg::ST_NOSPACE;
				end else begin
					pend_addr_q <= user_q[DW-1:0];
				end
			end
			ST_FIN: begin
				if (out_free) begin
					result_addr_q <= pend_addr_q;
					status_q      <= pend_status_q;
					reused_q      <= pend_reused_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_addr = result_addr_q;
	assign status      = status_q;
	assign reused      = reused_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	`FFBA_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "command did not start")
	`FFBA_ASSERT_ALWAYS(a_count_bound, count_q <= CNTW'(MAX_BLOCKS), "entry count past table")
	`FFBA_ASSERT_IMP(a_exit_in_search, probe_exit.act, state_q == ST_SEARCH, "token out of search")
	`FFBA_ASSERT_IMP(a_reuse_ok, out_valid && reused, status == ffba_pkg::ST_OK, "reuse not ok")

endmodule

/* sv/ffba_rem.sv */
// remainder of a 32-bit value by a fixed alignment, valid with done in the cycle after start
// byte residues come from constant tables and are folded by a final table; depends on ffba_pkg
module ffba_rem #(
	parameter int ALIGN = 16,
	parameter int RW    = $clog2(ALIGN) + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ffba_pkg::DATA_W-1:0] value,
	output logic                        done,
	output logic [RW-1:0]               rem
);

	// weight of each byte position modulo ALIGN
	localparam int W0 = 1 % ALIGN;
	localparam int W1 = 256 % ALIGN;
	localparam int W2 = (W1 * 256) % ALIGN;
	localparam int W3 = (W2 * 256) % ALIGN;

	logic [255:0][7:0]    tab0;
	logic [255:0][7:0]    tab1;
	logic [255:0][7:0]    tab2;
	logic [255:0][7:0]    tab3;
	logic [255:0][RW-1:0] tabf;
	logic [7:0]           sum;

	logic                 done_q;
	logic [RW-1:0]        rem_q;

	// constant residue tables, each entry below ALIGN
	for (genvar b = 0; b < 256; b++) begin : g_tab
		assign tab0[b] = 8'((b * W0) % ALIGN);
		assign tab1[b] = 8'((b * W1) % ALIGN);
		assign tab2[b] = 8'((b * W2) % ALIGN);
		assign tab3[b] = 8'((b * W3) % ALIGN);
		assign tabf[b] = RW'(b % ALIGN);
	end

	// four residues below ALIGN each, the sum stays under 256 while ALIGN is at most 64
	assign sum = tab0[value[7:0]] + tab1[value[15:8]] + tab2[value[23:16]] +
		tab3[value[31:24]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= tabf[sum];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* sv/ffba_cell.sv */
// one table entry of the allocator and its stage of the search row
// depends on ffba_pkg
module ffba_cell #(
	parameter int IDX  = 0,
	parameter int CNTW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [CNTW-1:0]             count,
	input  logic                        wr_en,
	input  logic [ffba_pkg::DATA_W-1:0] wr_addr,
	input  logic [ffba_pkg::DATA_W-1:0] wr_bytes,
	input  ffba_pkg::probe_t            probe_in,
	output ffba_pkg::probe_t            probe_out
);

	logic [ffba_pkg::DATA_W-1:0] addr_q;
	logic [ffba_pkg::DATA_W-1:0] bytes_q;
	logic                        free_q;
	ffba_pkg::probe_t            probe_q;
	ffba_pkg::probe_t            probe_d;

	logic in_range;
	logic fit;
	logic same_addr;
	logic match;

	assign in_range  = CNTW'(IDX) < count;
	assign fit       = free_q && ({2'b00, bytes_q} >= probe_in.key);
	assign same_addr = {2'b00, addr_q} == probe_in.key;
	assign match     = probe_in.act && !probe_in.hit && in_range &&
		((probe_in.cmd == ffba_pkg::CMD_FREE) ? same_addr : fit);

	// token handed on, marked with this entry on a match
	always_comb begin
		probe_d = probe_in;
		if (match) begin
			probe_d.hit      = 1'b1;
			probe_d.was_free = free_q;
			probe_d.hit_addr = addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
			if (wr_en && count == CNTW'(IDX)) begin
				free_q <= 1'b0;
			end else if (match) begin
				// alloc takes the block, free releases it if it was in use
				free_q <= (probe_in.cmd == ffba_pkg::CMD_FREE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && count == CNTW'(IDX)) begin
			addr_q  <= wr_addr;
			bytes_q <= wr_bytes;
		end
	end

	assign probe_out = probe_q;

endmodule

/* dv/first_fit_block_allocator_core_tb.sv */
// self-checking testbench for first_fit_block_allocator_core: directed rows, then random
// allocate/free traffic, checked against typed answers or an in-bench first-fit predictor
// depends on ffba_pkg and the allocator rtl
`timescale 1ns / 1ps

module first_fit_block_allocator_core_tb;

	localparam int CLK_PERIOD     = 12;
	localparam int MAX_BLOCKS     = 64;
	localparam int ALIGN_BYTES    = 16;
	localparam int HEADER_BYTES   = 32;
	localparam int ADDR_BITS      = 32;
	localparam int RESET_CYCLES   = 9;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 150;
	localparam int PHASES         = 4;
	localparam int PHASE_ITEMS    = 325;
	localparam int DW             = ffba_pkg::DATA_W;
	localparam int SW             = ffba_pkg::STAT_W;

	localparam logic [63:0] ADDR_MASK = 64'h0000_0000_FFFF_FFFF;

	localparam logic CMD_ALLOC = ffba_pkg::CMD_ALLOC;
	localparam logic CMD_FREE  = ffba_pkg::CMD_FREE;

	localparam logic [SW-1:0] ST_OK      = ffba_pkg::ST_OK;
	localparam logic [SW-1:0] ST_ZERO    = ffba_pkg::ST_ZERO;
	localparam logic [SW-1:0] ST_NOSPACE = ffba_pkg::ST_NOSPACE;
	localparam logic [SW-1:0] ST_FULL    = ffba_pkg::ST_FULL;
	localparam logic [SW-1:0] ST_INVAL   = ffba_pkg::ST_INVAL;

	// register byte addresses, one 32-bit word each
	localparam logic [2:0] ADDR_HEAP_START = {ffba_pkg::REG_HEAP_START, 2'b00};
	localparam logic [2:0] ADDR_HEAP_END   = {ffba_pkg::REG_HEAP_END, 2'b00};

	typedef struct packed {
		logic [DW-1:0] addr;
		logic [SW-1:0] status;
		logic          reused;
	} alloc_result_t;

	typedef enum logic [1:0] {ROW_CMD, ROW_SET_START, ROW_SET_END} row_kind_t;

	// one line of the directed part; typed rows carry their own answer
	typedef struct {
		row_kind_t     kind;
		logic          op;
		logic [31:0]   arg;
		logic [31:0]   uaddr;
		bit            typed;
		alloc_result_t want;
	} row_t;

	logic            clk        = 1'b0;
	logic            arst_n     = 1'b0;
	logic            psel       = 1'b0;
	logic            penable    = 1'b0;
	logic            pwrite     = 1'b0;
	logic [2:0]      paddr      = '0;
	logic [DW-1:0]   pwdata     = '0;
	logic [DW-1:0]   prdata;
	logic            pready;
	logic            in_valid   = 1'b0;
	logic            in_ready;
	logic            cmd        = ffba_pkg::CMD_ALLOC;
	logic [DW-1:0]   req_size   = '0;
	logic [DW-1:0]   user_addr  = '0;
	logic            out_valid;
	logic            out_ready  = 1'b0;
	logic [DW-1:0]   result_addr;
	logic [SW-1:0]   status;
	logic            reused;

	// predictor copy of the block table, break and registers
	logic [31:0]   blk_addr  [MAX_BLOCKS];
	logic [31:0]   blk_bytes [MAX_BLOCKS];
	bit            blk_free  [MAX_BLOCKS];
	int unsigned   blk_count = 0;
	logic [63:0]   heap_break = '0;
	logic [63:0]   heap_start = '0;
	logic [63:0]   heap_end   = 64'd65536;

	// results still owed by the block, oldest first
	alloc_result_t awaited_outcomes [$];

	int unsigned mismatches    = 0;
	int unsigned stalled_cycles = 0;
	int unsigned ready_hold    = 0;
	bit          steady_tail   = 1'b0;

	// tallies for the closing summary
	int unsigned n_alloc = 0, n_free = 0, n_reuse = 0, n_full = 0, n_nospace = 0;
	int unsigned n_inval = 0, n_results = 0;

	// directed part: extremes, the zero, no-space and invalid paths, the empty-table break, free and reuse
	row_t directed_rows [25] = '{
		// zero size, and both overflow paths with the default heap
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, ST_ZERO, 1'b0}},
		'{ROW_CMD, CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		'{ROW_CMD, CMD_ALLOC, 32'hFFFF_FFF0, 32'h0000_0000, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		// free of address zero is a no-op, free on an empty table is invalid
		'{ROW_CMD, CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, ST_OK, 1'b0}},
		'{ROW_CMD, CMD_FREE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_INVAL, 1'b0}},
		// break alignment wraps
		'{ROW_SET_START, CMD_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		// header add wraps
		'{ROW_SET_START, CMD_ALLOC, 32'hFFFF_FFE0, 32'h0, 1'b0, '0},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0010, 32'h0000_0000, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		// size add wraps even with the widest heap_end
		'{ROW_SET_START, CMD_ALLOC, 32'hFFFF_FFC0, 32'h0, 1'b0, '0},
		'{ROW_SET_END,   CMD_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0020, 32'h0000_0000, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		// block end past a zero heap_end
		'{ROW_SET_START, CMD_ALLOC, 32'h0000_0000, 32'h0, 1'b0, '0},
		'{ROW_SET_END,   CMD_ALLOC, 32'h0000_0000, 32'h0, 1'b0, '0},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		// unaligned start, first carves
		'{ROW_SET_START, CMD_ALLOC, 32'h0000_1003, 32'h0, 1'b0, '0},
		'{ROW_SET_END,   CMD_ALLOC, 32'h0001_0000, 32'h0, 1'b0, '0},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0011, 32'h0000_0000, 1'b0, '0},
		// free, double free, reuse of the freed block, free off by one
		'{ROW_CMD, CMD_FREE,  32'h0000_0000, 32'h0000_1030, 1'b1, '{32'h0, ST_OK, 1'b0}},
		'{ROW_CMD, CMD_FREE,  32'h0000_0000, 32'h0000_1030, 1'b1, '{32'h0, ST_INVAL, 1'b0}},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0010, 32'h0000_0000, 1'b1, '{32'h1030, ST_OK, 1'b1}},
		'{ROW_CMD, CMD_FREE,  32'h0000_0000, 32'h0000_1031, 1'b1, '{32'h0, ST_INVAL, 1'b0}},
		// too big for the remaining heap
		'{ROW_CMD, CMD_ALLOC, 32'h0001_0000, 32'h0000_0000, 1'b1, '{32'h0, ST_NOSPACE, 1'b0}},
		'{ROW_CMD, CMD_ALLOC, 32'h0000_0008, 32'h0000_0000, 1'b0, '0}
	};

	first_fit_block_allocator_core #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.ALIGN_BYTES (ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.req_size   (req_size),
		.user_addr  (user_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_addr(result_addr),
		.status     (status),
		.reused     (reused)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// round up to the alignment in 64 bits, so a wrap shows as a value above the mask
	function automatic logic [63:0] align_up(input logic [63:0] v);
		return ((v + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES)) * 64'(ALIGN_BYTES);
	endfunction

	// first-fit outcome of one command, updating the predictor table
	function automatic alloc_result_t first_fit_outcome(input logic op,
		input logic [31:0] size, input logic [31:0] uaddr);
		alloc_result_t r;
		logic [63:0]   asz;
		logic [63:0]   base;
		logic [63:0]   user;
		logic [63:0]   blk_end;
		bit            hit;
		r = '{addr: '0, status: ST_OK, reused: 1'b0};
		hit = 1'b0;
		if (op == CMD_ALLOC) begin
			asz = align_up({32'b0, size});
			if (size == '0) begin
				r.status = ST_ZERO;
			end else if (asz > ADDR_MASK) begin
				r.status = ST_NOSPACE;
			end else begin
				// oldest free entry that is big enough
				for (int i = 0; i < blk_count && !hit; i++) begin
					if (blk_free[i] && {32'b0, blk_bytes[i]} >= asz) begin
						hit = 1'b1;
						blk_free[i] = 1'b0;
						r.addr = blk_addr[i];
						r.reused = 1'b1;
					end
				end
				if (!hit) begin
					// the break comes from heap_start until the first block exists
					base = (blk_count == 0) ? heap_start : heap_break;
					user = align_up(base) + 64'(HEADER_BYTES);
					blk_end = user + asz;
					// heap_end never exceeds the mask, so one compare covers every wrap
					if (blk_count >= MAX_BLOCKS) begin
						r.status = ST_FULL;
					end else if (blk_end > heap_end) begin
						r.status = ST_NOSPACE;
					end else begin
						blk_addr[blk_count] = user[31:0];
						blk_bytes[blk_count] = asz[31:0];
						blk_free[blk_count] = 1'b0;
						blk_count++;
						heap_break = blk_end;
						r.addr = user[31:0];
					end
				end
			end
		end else if (uaddr != '0) begin
			r.status = ST_INVAL;
			for (int i = 0; i < blk_count && !hit; i++) begin
				if (blk_addr[i] == uaddr) begin
					hit = 1'b1;
					if (!blk_free[i]) begin
						blk_free[i] = 1'b1;
						r.status = ST_OK;
					end
				end
			end
		end
		return r;
	endfunction

	// present one command, hold it until the transfer, then log what it must produce
	task automatic push_command(input logic op, input logic [31:0] size,
		input logic [31:0] uaddr, input bit typed, input alloc_result_t want);
		alloc_result_t predicted;
		in_valid <= 1'b1;
		cmd <= op;
		req_size <= size;
		user_addr <= uaddr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// the predictor runs for every row so its table tracks the block
		predicted = first_fit_outcome(op, size, uaddr);
		if (typed)
			predicted = want;
		awaited_outcomes.push_back(predicted);
		if (op == CMD_ALLOC) n_alloc++; else n_free++;
		if (predicted.reused) n_reuse++;
		if (predicted.status == ST_FULL) n_full++;
		if (predicted.status == ST_NOSPACE) n_nospace++;
		if (predicted.status == ST_INVAL) n_inval++;
		// input-side idle burst, skipped in the steady tail
		if (!steady_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// register write once the block has answered everything it took
	task automatic program_register(input logic [2:0] addr, input logic [31:0] data);
		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		// setup phase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		// access phase, the write lands on the edge where pready is seen high
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_HEAP_START)
			heap_start = {32'b0, data};
		else
			heap_end = {32'b0, data};
		@(posedge clk);
	endtask

	// random command: mostly small allocations and frees of live table addresses,
	// plus wide sizes, stray addresses and misaligned frees
	task automatic pick_command(output logic op, output logic [31:0] size,
		output logic [31:0] uaddr);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		op = (roll < 45) ? CMD_ALLOC : CMD_FREE;
		// the field the command ignores still gets random bits
		size = $urandom;
		uaddr = $urandom;
		if (roll < 40) begin
			size = $urandom_range(1, 512);
		end else if (roll < 45) begin
			size = $urandom >> $urandom_range(0, 31);
		end else if (roll < 80) begin
			uaddr = (blk_count == 0) ? '0 : blk_addr[$urandom_range(0, blk_count - 1)];
		end else if (roll < 92 && roll >= 88) begin
			uaddr = '0;
		end else if (roll >= 92) begin
			uaddr = (blk_count == 0) ? $urandom :
				blk_addr[$urandom_range(0, blk_count - 1)] + $urandom_range(1, 15);
		end
	endtask

	// result side: random stall bursts between ready runs, none in the steady tail
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (steady_tail || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
			ready_hold <= $urandom_range(0, 20);
		end else begin
			out_ready <= 1'b0;
			ready_hold <= $urandom_range(0, 14);
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		alloc_result_t exp_res;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (awaited_outcomes.size() == 0) begin
					$error("result transfer with nothing outstanding: addr %h status %0d reused %0d",
						result_addr, status, reused);
					mismatches++;
				end else begin
					exp_res = awaited_outcomes.pop_front();
					if (result_addr !== exp_res.addr) begin
						$error("result_addr: expected %h, got %h", exp_res.addr, result_addr);
						mismatches++;
					end
					if (status !== exp_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status, status);
						mismatches++;
					end
					if (reused !== exp_res.reused) begin
						$error("reused: expected %0d, got %0d", exp_res.reused, reused);
						mismatches++;
					end
				end
			end
			// count cycles with no transfer on either channel
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					stalled_cycles, awaited_outcomes.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] phase_end [PHASES];
		logic        op;
		logic [31:0] size;
		logic [31:0] uaddr;
		// tight heap first, then the widest, a random middle one, and zero
		phase_end[0] = 32'h0000_4000;
		phase_end[1] = 32'hFFFF_FFFF;
		phase_end[2] = $urandom_range(32'h0000_8000, 32'h0004_0000);
		phase_end[3] = 32'h0000_0000;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_SET_START: program_register(ADDR_HEAP_START, directed_rows[i].arg);
				ROW_SET_END:   program_register(ADDR_HEAP_END, directed_rows[i].arg);
				default:       push_command(directed_rows[i].op, directed_rows[i].arg,
					directed_rows[i].uaddr, directed_rows[i].typed, directed_rows[i].want);
			endcase
		end

		// random phases, one heap_start and heap_end setting each
		for (int p = 0; p < PHASES; p++) begin
			program_register(ADDR_HEAP_START, $urandom);
			program_register(ADDR_HEAP_END, phase_end[p]);
			if (p == PHASES - 1)
				steady_tail = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick_command(op, size, uaddr);
				push_command(op, size, uaddr, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		// catch any stray result after the last one
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d allocations and %0d frees over %0d heap settings, %0d results",
			n_alloc, n_free, PHASES + 1, n_results);
		$display("seen %0d reuses, %0d table-full, %0d no-space, %0d invalid frees, %0d blocks",
			n_reuse, n_full, n_nospace, n_inval, blk_count);
		if (mismatches == 0 && awaited_outcomes.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* first_fit_block_allocator_core.f */
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_rem.sv
sv/ffba_cell.sv
sv/first_fit_block_allocator_core.sv
dv/first_fit_block_allocator_core_tb.sv
